// File: hdl/wlm_pkg.sv
// ----------------------------------------------------------------------------
// wlm_pkg
// Types and constants shared by the windowed level meter modules.
// ----------------------------------------------------------------------------
package wlm_pkg;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] primary_sample;
    logic signed [15:0] ref_sample;
    logic               end_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic               report_kind;
    logic [15:0]        level_peak;
    logic [15:0]        level_rms;
    logic [15:0]        far_peak;
    logic [15:0]        ref_rms;
    logic [15:0]        mic_pk_hold_out;
    logic [15:0]        far_pk_hold_out;
    logic [15:0]        mic_rms_top_out;
    logic [15:0]        far_rms_top_out;
    logic signed [15:0] erle_db;
    logic               erle_updated;
    logic signed [15:0] erle_best;
  } out_beat_t;

  // closed window handed from the accumulator to the back end
  typedef struct packed {
    logic        kind;
    logic [63:0] lvl_sum;
    logic [31:0] cnt;
    logic [15:0] lvl_peak;
    logic [63:0] ref_sum;
    logic [15:0] far_peak;
  } job_t;

  localparam logic        KIND_IN      = 1'b0;
  localparam logic        KIND_OUT     = 1'b1;
  localparam logic [15:0] WIN_RESET    = 16'd4000;
  localparam logic [31:0] CNT_MAX      = 32'hFFFF_FFFF;
  localparam logic [29:0] DB_PER_OCT   = 30'd808071242;
  localparam int          QUEUE_DEPTH  = 2;

endpackage

// File: hdl/wlm_front.sv
// ----------------------------------------------------------------------------
// wlm_front
// Per-sample accumulation of squares, peaks and counts; emits closed windows.
// ----------------------------------------------------------------------------
module wlm_front import wlm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic     acc,
  input  in_beat_t beat,
  output logic     push,
  output job_t     push_job
);

  logic [15:0] win_r;
  logic [63:0] mic_sum_r, ref_sum_r, out_sum_r;
  logic [15:0] mic_pk_r, ref_pk_r, out_pk_r;
  logic [31:0] in_cnt_r, out_cnt_r;

  logic [15:0] pa, ra, win_eff;
  logic signed [31:0] psq_s, rsq_s;
  logic [63:0] psq, rsq;
  logic [15:0] mic_pk_nxt, ref_pk_nxt, out_pk_nxt;
  logic [63:0] mic_sum_nxt, ref_sum_nxt, out_sum_nxt;
  logic [31:0] in_cnt_nxt, out_cnt_nxt, cnt_sel;
  logic        close;

  always_comb begin
    pa = beat.primary_sample[15] ? 16'(-beat.primary_sample) : 16'(beat.primary_sample);
    ra = beat.ref_sample[15] ? 16'(-beat.ref_sample) : 16'(beat.ref_sample);
    psq_s = beat.primary_sample * beat.primary_sample;
    rsq_s = beat.ref_sample * beat.ref_sample;
    psq = {32'b0, psq_s};
    rsq = {32'b0, rsq_s};
    win_eff = (win_r == 16'd0) ? 16'd1 : win_r;
    mic_pk_nxt = (pa > mic_pk_r) ? pa : mic_pk_r;
    ref_pk_nxt = (ra > ref_pk_r) ? ra : ref_pk_r;
    out_pk_nxt = (pa > out_pk_r) ? pa : out_pk_r;
    if (in_cnt_r != CNT_MAX) begin
      mic_sum_nxt = mic_sum_r + psq;
      ref_sum_nxt = ref_sum_r + rsq;
      in_cnt_nxt  = in_cnt_r + 32'd1;
    end else begin
      mic_sum_nxt = mic_sum_r;
      ref_sum_nxt = ref_sum_r;
      in_cnt_nxt  = in_cnt_r;
    end
    if (out_cnt_r != CNT_MAX) begin
      out_sum_nxt = out_sum_r + psq;
      out_cnt_nxt = out_cnt_r + 32'd1;
    end else begin
      out_sum_nxt = out_sum_r;
      out_cnt_nxt = out_cnt_r;
    end
    cnt_sel = (beat.kind == KIND_OUT) ? out_cnt_nxt : in_cnt_nxt;
    close = beat.end_of_frame && (cnt_sel >= {16'b0, win_eff});
    push = acc && close;
    push_job.kind = beat.kind;
    push_job.cnt  = cnt_sel;
    if (beat.kind == KIND_OUT) begin
      push_job.lvl_sum  = out_sum_nxt;
      push_job.lvl_peak = out_pk_nxt;
      push_job.ref_sum  = 64'd0;
      push_job.far_peak = 16'd0;
    end else begin
      push_job.lvl_sum  = mic_sum_nxt;
      push_job.lvl_peak = mic_pk_nxt;
      push_job.ref_sum  = ref_sum_nxt;
      push_job.far_peak = ref_pk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= WIN_RESET;
      mic_sum_r <= '0;
      ref_sum_r <= '0;
      out_sum_r <= '0;
      mic_pk_r  <= '0;
      ref_pk_r  <= '0;
      out_pk_r  <= '0;
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      if (acc && beat.kind == KIND_IN) begin
        if (close) begin
          mic_sum_r <= '0;
          ref_sum_r <= '0;
          mic_pk_r  <= '0;
          ref_pk_r  <= '0;
          in_cnt_r  <= '0;
        end else begin
          mic_sum_r <= mic_sum_nxt;
          ref_sum_r <= ref_sum_nxt;
          mic_pk_r  <= mic_pk_nxt;
          ref_pk_r  <= ref_pk_nxt;
          in_cnt_r  <= in_cnt_nxt;
        end
      end
      if (acc && beat.kind == KIND_OUT) begin
        if (close) begin
          out_sum_r <= '0;
          out_pk_r  <= '0;
          out_cnt_r <= '0;
        end else begin
          out_sum_r <= out_sum_nxt;
          out_pk_r  <= out_pk_nxt;
          out_cnt_r <= out_cnt_nxt;
        end
      end
    end
  end

endmodule

// File: hdl/wlm_queue.sv
// ----------------------------------------------------------------------------
// wlm_queue
// Short FIFO of closed windows between accumulator and back end.
// ----------------------------------------------------------------------------
module wlm_queue import wlm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t q_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> !full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// File: hdl/wlm_back.sv
// ----------------------------------------------------------------------------
// wlm_back
// Window close: serial divide, serial square root, log2 by squaring, ERLE,
// session max-holds and the output register.
// ----------------------------------------------------------------------------
module wlm_back import wlm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV   = 4'd1;
  localparam logic [3:0] ST_SQI   = 4'd2;
  localparam logic [3:0] ST_SQRT  = 4'd3;
  localparam logic [3:0] ST_RMS   = 4'd4;
  localparam logic [3:0] ST_LNORM = 4'd5;
  localparam logic [3:0] ST_LMUL  = 4'd6;
  localparam logic [3:0] ST_LSQR  = 4'd7;
  localparam logic [3:0] ST_LACC  = 4'd8;
  localparam logic [3:0] ST_MULH  = 4'd9;
  localparam logic [3:0] ST_MULL  = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;
  localparam logic [3:0] ST_UPD   = 4'd12;
  localparam logic [3:0] ST_EMIT  = 4'd13;

  logic [3:0]  st_r;
  job_t        job_r;
  logic        sel_r;
  logic [5:0]  step_r;
  logic [63:0] dvd_r;
  logic [31:0] rem_r, quot_r, rad_r;
  logic [17:0] srem_r;
  logic [15:0] root_r, lvl_rms_r, ref_rms_r;
  logic [63:0] lx_r, prod_r;
  logic [5:0]  ln_r;
  logic [31:0] lm_r;
  logic [23:0] frac_r;
  logic [1:0]  li_r;
  logic signed [32:0] d_r;
  logic [46:0] ph_r, pl_r;
  logic        upd_r;
  logic [63:0] last_mic_sum_r;
  logic [31:0] last_mic_cnt_r;
  logic [15:0] mic_pk_hold_r, ref_pk_hold_r, mic_rms_top_r, ref_rms_top_r;
  logic signed [15:0] erle_last_r, erle_best_r;
  logic        out_valid_r;
  out_beat_t   out_r;

  logic [32:0] dt, st_t;
  logic        dge;
  logic [19:0] sq_t, sq_trial;
  logic        sge;
  logic [63:0] lop_nxt;
  logic signed [32:0] lres;
  logic        dneg;
  logic [32:0] dabs, amag;
  logic [63:0] tot;
  logic [19:0] q;
  logic signed [15:0] erle_val;
  logic        can_emit, erle_ok;

  always_comb begin
    dt   = {rem_r, dvd_r[63]};
    dge  = dt >= {1'b0, job_r.cnt};
    st_t = dt - {1'b0, job_r.cnt};
    sq_t = {srem_r, rad_r[31:30]};
    sq_trial = {2'b0, root_r, 2'b01};
    sge  = sq_t >= sq_trial;
    case (li_r)
      2'd0:    lop_nxt = {32'b0, last_mic_cnt_r};
      2'd1:    lop_nxt = job_r.lvl_sum;
      default: lop_nxt = {32'b0, job_r.cnt};
    endcase
    lres = 33'(signed'({3'b0, ln_r, frac_r}));
    dneg = d_r[32];
    dabs = dneg ? 33'(-d_r) : 33'(d_r);
    amag = (dabs > 33'h1_0000_0000) ? 33'h1_0000_0000 : dabs;
    tot  = {1'b0, ph_r, 16'b0} + {17'b0, pl_r} + 64'h0000_0800_0000_0000;
    q    = tot[63:44];
    if (dneg) begin
      erle_val = (q > 20'd32768) ? 16'sh8000 : 16'(20'd0 - q);
    end else begin
      erle_val = (q > 20'd32767) ? 16'sh7FFF : 16'(q);
    end
    erle_ok  = (job_r.lvl_sum > {32'b0, job_r.cnt}) &&
               (last_mic_sum_r > {32'b0, last_mic_cnt_r});
    can_emit = !out_valid_r || !out_stall;
    pop      = (st_r == ST_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= ST_IDLE;
      upd_r          <= 1'b0;
      last_mic_sum_r <= '0;
      last_mic_cnt_r <= '0;
      mic_pk_hold_r  <= '0;
      ref_pk_hold_r  <= '0;
      mic_rms_top_r  <= '0;
      ref_rms_top_r  <= '0;
      erle_last_r    <= '0;
      erle_best_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (st_r == ST_EMIT && can_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            job_r  <= q_job;
            dvd_r  <= q_job.lvl_sum;
            rem_r  <= '0;
            quot_r <= '0;
            step_r <= '0;
            sel_r  <= 1'b0;
            upd_r  <= 1'b0;
            st_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r  <= dge ? st_t[31:0] : dt[31:0];
          dvd_r  <= {dvd_r[62:0], 1'b0};
          quot_r <= {quot_r[30:0], dge};
          step_r <= step_r + 6'd1;
          if (step_r == 6'd63) begin
            st_r <= ST_SQI;
          end
        end
        ST_SQI: begin
          rad_r  <= quot_r;
          srem_r <= '0;
          root_r <= '0;
          step_r <= '0;
          st_r   <= ST_SQRT;
        end
        ST_SQRT: begin
          srem_r <= sge ? 18'(sq_t - sq_trial) : 18'(sq_t);
          root_r <= {root_r[14:0], sge};
          rad_r  <= {rad_r[29:0], 2'b00};
          step_r <= step_r + 6'd1;
          if (step_r == 6'd15) begin
            st_r <= ST_RMS;
          end
        end
        ST_RMS: begin
          if (sel_r) begin
            ref_rms_r <= root_r;
            st_r      <= ST_UPD;
          end else begin
            lvl_rms_r <= root_r;
            if (job_r.kind == KIND_IN) begin
              sel_r  <= 1'b1;
              dvd_r  <= job_r.ref_sum;
              rem_r  <= '0;
              quot_r <= '0;
              step_r <= '0;
              st_r   <= ST_DIV;
            end else begin
              ref_rms_r <= '0;
              if (erle_ok) begin
                li_r <= 2'd0;
                lx_r <= last_mic_sum_r;
                ln_r <= 6'd63;
                d_r  <= '0;
                st_r <= ST_LNORM;
              end else begin
                st_r <= ST_EMIT;
              end
            end
          end
        end
        ST_LNORM: begin
          if (lx_r == 64'd0) begin
            ln_r   <= '0;
            frac_r <= '0;
            st_r   <= ST_LACC;
          end else if (!lx_r[63]) begin
            lx_r <= {lx_r[62:0], 1'b0};
            ln_r <= ln_r - 6'd1;
          end else begin
            lm_r   <= lx_r[63:32];
            frac_r <= '0;
            step_r <= '0;
            st_r   <= ST_LMUL;
          end
        end
        ST_LMUL: begin
          prod_r <= 64'(lm_r) * 64'(lm_r);
          st_r   <= ST_LSQR;
        end
        ST_LSQR: begin
          frac_r <= {frac_r[22:0], prod_r[63]};
          lm_r   <= prod_r[63] ? prod_r[63:32] : prod_r[62:31];
          step_r <= step_r + 6'd1;
          st_r   <= (step_r == 6'd23) ? ST_LACC : ST_LMUL;
        end
        ST_LACC: begin
          if (li_r == 2'd1 || li_r == 2'd2) begin
            d_r <= d_r - lres;
          end else begin
            d_r <= d_r + lres;
          end
          if (li_r == 2'd3) begin
            st_r <= ST_MULH;
          end else begin
            li_r <= li_r + 2'd1;
            lx_r <= lop_nxt;
            ln_r <= 6'd63;
            st_r <= ST_LNORM;
          end
        end
        ST_MULH: begin
          ph_r <= 47'(amag[32:16]) * 47'(DB_PER_OCT);
          st_r <= ST_MULL;
        end
        ST_MULL: begin
          pl_r <= 47'(amag[15:0]) * 47'(DB_PER_OCT);
          st_r <= ST_FIN;
        end
        ST_FIN: begin
          erle_last_r <= erle_val;
          if (erle_val > erle_best_r) begin
            erle_best_r <= erle_val;
          end
          upd_r <= 1'b1;
          st_r  <= ST_EMIT;
        end
        ST_UPD: begin
          last_mic_sum_r <= job_r.lvl_sum;
          last_mic_cnt_r <= job_r.cnt;
          if (job_r.lvl_peak > mic_pk_hold_r) mic_pk_hold_r <= job_r.lvl_peak;
          if (job_r.far_peak > ref_pk_hold_r) ref_pk_hold_r <= job_r.far_peak;
          if (lvl_rms_r > mic_rms_top_r) mic_rms_top_r <= lvl_rms_r;
          if (ref_rms_r > ref_rms_top_r) ref_rms_top_r <= ref_rms_r;
          st_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (can_emit) begin
            out_r.report_kind     <= job_r.kind;
            out_r.level_peak      <= job_r.lvl_peak;
            out_r.level_rms       <= lvl_rms_r;
            out_r.far_peak        <= job_r.far_peak;
            out_r.ref_rms         <= ref_rms_r;
            out_r.mic_pk_hold_out <= mic_pk_hold_r;
            out_r.far_pk_hold_out <= ref_pk_hold_r;
            out_r.mic_rms_top_out <= mic_rms_top_r;
            out_r.far_rms_top_out <= ref_rms_top_r;
            out_r.erle_db         <= erle_last_r;
            out_r.erle_updated    <= upd_r;
            out_r.erle_best       <= erle_best_r;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 erle_best_r >= $past(erle_best_r)) else $error("erle best decreased");
  a_upd_only_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.erle_updated |-> out_r.report_kind == KIND_OUT)
    else $error("erle update on input report");
  a_out_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.report_kind == KIND_OUT |->
      out_r.far_peak == 16'd0 && out_r.ref_rms == 16'd0)
    else $error("ref fields set in output report");

endmodule

// File: hdl/windowed_level_meter_with_erle.sv
// ----------------------------------------------------------------------------
// windowed_level_meter_with_erle
// Windowed peak / RMS meter for mic, reference and output with ERLE.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall) carry either a mic/reference pair or a
// post-cancellation sample. One sample is taken per cycle while in_stall
// is low; squares, peaks and counts accumulate in the front end in the
// accept cycle. On end_of_frame with a full window, the window is queued
// (two deep) and the back end computes it: 64-step divide and 16-step root
// per RMS, and for output windows four log2 evaluations (up to 63 normalize
// steps, then one squaring per fraction bit, each).
// in_stall rises only while both queue slots hold pending windows.
// A report waits in the output register while out_stall is high; the back
// end computes its next window but waits to emit until the register frees.
// Reset clears all accumulators, holds and ERLE and sets window_length to
// 4000. cfg_wr_en writes window_length (zero acts as one).
// ----------------------------------------------------------------------------
module windowed_level_meter_with_erle import wlm_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat
);

  logic push, full, pop, q_valid, acc;
  job_t push_job, q_job;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  wlm_front u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .acc, .beat(in_beat), .push, .push_job
  );

  wlm_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n, .push, .push_job, .full, .pop, .q_valid, .q_job
  );

  wlm_back u_back (
    .clk, .rst_n, .q_valid, .q_job, .pop, .out_valid, .out_stall, .out_beat
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed level meter with ERLE. A driver feeds
// sample beats from a queue, a predictor computes each window report, and a
// monitor compares every report field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import wlm_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  windowed_level_meter_with_erle uut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

  always #5 clk = ~clk;

  in_beat_t  pending_beats[$];
  out_beat_t expected_reports[$];
  int        error_count = 0;
  bit        hold_off = 1'b0;
  bit        quiet = 1'b0;

  // meter state
  logic [15:0] win_len;
  logic [63:0] mic_sum, ref_sum, out_sum, prev_mic_sum;
  logic [15:0] mic_pk, ref_pk, out_pk;
  logic [31:0] in_cnt, out_cnt, prev_mic_cnt;
  logic [15:0] mic_pk_hold, ref_pk_hold, mic_rms_hi, ref_rms_hi;
  logic signed [15:0] erle_now, erle_top;

  function automatic logic [15:0] magnitude(logic signed [15:0] s);
    logic signed [16:0] w;
    w = s;
    if (w < 0) w = -w;
    return w[15:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] window_root(logic [63:0] sum, logic [31:0] cnt);
    logic [63:0] r;
    if (cnt == 0) return 16'd0;
    r = int_sqrt(sum / {32'd0, cnt});
    return r[15:0];
  endfunction

  function automatic longint log2_fixed(logic [63:0] x);
    int n;
    logic [63:0] m;
    logic [127:0] sq;
    longint res;
    if (x == 0) return 0;
    n = 63;
    while (!x[n]) n--;
    if (n >= 31) m = x >> (n - 31);
    else m = x << (31 - n);
    res = longint'(n) << 24;
    for (int i = 23; i >= 0; i--) begin
      sq = {64'd0, m} * {64'd0, m};
      m = sq[94:31];
      if (m >= (64'd1 << 32)) begin
        res += longint'(1) << i;
        m = m >> 1;
      end
    end
    return res;
  endfunction

  function automatic logic signed [15:0] erle_from_sums();
    longint d;
    logic [63:0] a, q;
    bit neg;
    d = log2_fixed(prev_mic_sum) - log2_fixed({32'd0, prev_mic_cnt})
      - log2_fixed(out_sum) + log2_fixed({32'd0, out_cnt});
    neg = d < 0;
    a = neg ? -d : d;
    if (a > (64'd1 << 32)) a = 64'd1 << 32;
    q = (a * 64'd808071242 + (64'd1 << 43)) >> 44;
    if (neg) return (q > 32768) ? 16'sh8000 : -$signed(q[15:0]);
    return (q > 32767) ? 16'sh7fff : $signed(q[15:0]);
  endfunction

  function automatic void meter_reset();
    win_len = WIN_RESET;
    {mic_sum, ref_sum, out_sum, prev_mic_sum} = '0;
    {mic_pk, ref_pk, out_pk} = '0;
    {in_cnt, out_cnt, prev_mic_cnt} = '0;
    {mic_pk_hold, ref_pk_hold, mic_rms_hi, ref_rms_hi} = '0;
    erle_now = 0;
    erle_top = 0;
  endfunction

  function automatic void predict_report(in_beat_t b);
    out_beat_t r;
    logic [31:0] w;
    logic [15:0] pa, ra;
    logic signed [31:0] pw, rw;
    w = (win_len == 0) ? 32'd1 : {16'd0, win_len};
    pa = magnitude(b.primary_sample);
    pw = b.primary_sample;
    r = '0;
    if (b.kind == KIND_IN) begin
      ra = magnitude(b.ref_sample);
      rw = b.ref_sample;
      if (pa > mic_pk) mic_pk = pa;
      if (ra > ref_pk) ref_pk = ra;
      if (in_cnt != CNT_MAX) begin
        mic_sum += 64'(pw * pw);
        ref_sum += 64'(rw * rw);
        in_cnt++;
      end
      if (!b.end_of_frame || in_cnt < w) return;
      r.report_kind = KIND_IN;
      r.level_peak = mic_pk;
      r.level_rms = window_root(mic_sum, in_cnt);
      r.far_peak = ref_pk;
      r.ref_rms = window_root(ref_sum, in_cnt);
      prev_mic_sum = mic_sum;
      prev_mic_cnt = in_cnt;
      if (r.level_peak > mic_pk_hold) mic_pk_hold = r.level_peak;
      if (r.far_peak > ref_pk_hold) ref_pk_hold = r.far_peak;
      if (r.level_rms > mic_rms_hi) mic_rms_hi = r.level_rms;
      if (r.ref_rms > ref_rms_hi) ref_rms_hi = r.ref_rms;
      mic_sum = 0; ref_sum = 0; mic_pk = 0; ref_pk = 0; in_cnt = 0;
    end else begin
      if (pa > out_pk) out_pk = pa;
      if (out_cnt != CNT_MAX) begin
        out_sum += 64'(pw * pw);
        out_cnt++;
      end
      if (!b.end_of_frame || out_cnt < w) return;
      r.report_kind = KIND_OUT;
      r.level_peak = out_pk;
      r.level_rms = window_root(out_sum, out_cnt);
      if (out_sum > {32'd0, out_cnt} && prev_mic_sum > {32'd0, prev_mic_cnt}) begin
        erle_now = erle_from_sums();
        if (erle_now > erle_top) erle_top = erle_now;
        r.erle_updated = 1'b1;
      end
      out_sum = 0; out_pk = 0; out_cnt = 0;
    end
    r.mic_pk_hold_out = mic_pk_hold;
    r.far_pk_hold_out = ref_pk_hold;
    r.mic_rms_top_out = mic_rms_hi;
    r.far_rms_top_out = ref_rms_hi;
    r.erle_db = erle_now;
    r.erle_best = erle_top;
    expected_reports.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_report(in_beat);
        void'(pending_beats.pop_front());
        send_gap = quiet ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_valid <= 1'b1;
          in_beat <= pending_beats[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          e = expected_reports.pop_front();
          if (out_beat.report_kind !== e.report_kind)
            report_mismatch("report_kind", out_beat.report_kind, e.report_kind);
          if (out_beat.level_peak !== e.level_peak)
            report_mismatch("level_peak", out_beat.level_peak, e.level_peak);
          if (out_beat.level_rms !== e.level_rms)
            report_mismatch("level_rms", out_beat.level_rms, e.level_rms);
          if (out_beat.far_peak !== e.far_peak)
            report_mismatch("far_peak", out_beat.far_peak, e.far_peak);
          if (out_beat.ref_rms !== e.ref_rms)
            report_mismatch("ref_rms", out_beat.ref_rms, e.ref_rms);
          if (out_beat.mic_pk_hold_out !== e.mic_pk_hold_out)
            report_mismatch("mic_pk_hold", out_beat.mic_pk_hold_out, e.mic_pk_hold_out);
          if (out_beat.far_pk_hold_out !== e.far_pk_hold_out)
            report_mismatch("far_pk_hold", out_beat.far_pk_hold_out, e.far_pk_hold_out);
          if (out_beat.mic_rms_top_out !== e.mic_rms_top_out)
            report_mismatch("mic_rms_top", out_beat.mic_rms_top_out, e.mic_rms_top_out);
          if (out_beat.far_rms_top_out !== e.far_rms_top_out)
            report_mismatch("far_rms_top", out_beat.far_rms_top_out, e.far_rms_top_out);
          if (out_beat.erle_db !== e.erle_db)
            report_mismatch("erle_db", out_beat.erle_db, e.erle_db);
          if (out_beat.erle_updated !== e.erle_updated)
            report_mismatch("erle_updated", out_beat.erle_updated, e.erle_updated);
          if (out_beat.erle_best !== e.erle_best)
            report_mismatch("erle_best", out_beat.erle_best, e.erle_best);
        end
        recv_gap = quiet ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_beat_t make_beat(logic k, logic signed [15:0] p,
                                         logic signed [15:0] r, logic eof);
    in_beat_t b;
    b.kind = k;
    b.primary_sample = p;
    b.ref_sample = r;
    b.end_of_frame = eof;
    return b;
  endfunction

  function automatic logic signed [15:0] rand_sample(int scale);
    int v;
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $signed(16'($urandom));
      default: begin
        v = $urandom_range(0, 2 * scale) - scale;
        return 16'(v);
      end
    endcase
  endfunction

  task automatic drain();
    while (pending_beats.size() > 0 || expected_reports.size() > 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_len = v;
  endtask

  // frames of random length with random content
  task automatic queue_frames(int beats, int scale);
    int k;
    for (int i = 0; i < beats; i++) begin
      k = ($urandom_range(0, 9) < 5) ? 0 : 1;
      pending_beats.push_back(make_beat(k[0], rand_sample(scale), rand_sample(scale),
                                        $urandom_range(0, 5) == 0));
    end
  endtask

  initial begin
    meter_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short window, extremes, frame end before full, silent output
    write_window(16'd3);
    pending_beats.push_back(make_beat(KIND_IN, 16'sh8000, 16'sh7fff, 1'b1));
    pending_beats.push_back(make_beat(KIND_IN, 16'sh7fff, 16'sh8000, 1'b0));
    pending_beats.push_back(make_beat(KIND_IN, 16'sh0001, -16'sd1, 1'b1));
    pending_beats.push_back(make_beat(KIND_OUT, 16'sh0000, 16'sh7fff, 1'b0));
    pending_beats.push_back(make_beat(KIND_OUT, 16'sh0001, 16'sh8000, 1'b0));
    pending_beats.push_back(make_beat(KIND_OUT, 16'sh0000, 16'sh5555, 1'b1));
    pending_beats.push_back(make_beat(KIND_OUT, 16'sh8000, 16'sh0000, 1'b0));
    pending_beats.push_back(make_beat(KIND_OUT, 16'sh7fff, 16'shaaaa, 1'b0));
    pending_beats.push_back(make_beat(KIND_OUT, 16'sh0100, 16'sh0000, 1'b1));
    pending_beats.push_back(make_beat(KIND_IN, 16'sh0010, 16'sh0000, 1'b0));
    pending_beats.push_back(make_beat(KIND_IN, -16'sd16, 16'sh0000, 1'b1));
    pending_beats.push_back(make_beat(KIND_OUT, 16'sh7000, 16'sh0000, 1'b1));
    pending_beats.push_back(make_beat(KIND_OUT, 16'sh0001, 16'sh0000, 1'b1));
    drain();

    // zero acts as one: every frame end reports
    write_window(16'd0);
    for (int i = 0; i < 8; i++)
      pending_beats.push_back(make_beat(i[0], rand_sample(30000), rand_sample(30000), 1'b1));
    drain();

    // input stalls: receiver held off while sender keeps offering
    write_window(16'd1);
    hold_off = 1'b1;
    quiet = 1'b1;
    queue_frames(40, 2000);
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
    quiet = 1'b0;
    drain();

    write_window(16'd5);
    queue_frames(600, 8000);
    drain();
    write_window(16'd2);
    queue_frames(600, 300);
    drain();
    write_window(16'd65535);
    queue_frames(200, 20000);
    drain();
    write_window(16'd12);
    queue_frames(300, 32768);
    drain();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hdl/wlm_pkg.sv
hdl/wlm_front.sv
hdl/wlm_queue.sv
hdl/wlm_back.sv
hdl/windowed_level_meter_with_erle.sv
tb/tb_top.sv
